>>> rtl/core/kidfl_pkg.sv
// Shared types and constants for the key id free list allocator.
package kidfl_pkg;

    // Size of the id pool; ids run from 1 to CAPACITY
    localparam int CAPACITY = 1024;

    // Payload field widths
    localparam int ID_W     = 11;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 16;

    // Request kinds carried in the input tuser
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    // Result status carried in the output tuser
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_REJECT  = 2'd2,
        STAT_CLEARED = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

endpackage

>>> rtl/core/kidfl_mem.sv
// Single-port-write, single-port-read slot memory with registered read data.
module kidfl_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/kidfl_ctrl.sv
// Sequencer: free list head, high-water mark, slot read-modify-write and result register.
module kidfl_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  logic [kidfl_pkg::MODE_W-1:0]  i_req_mode,
    input  logic [kidfl_pkg::ID_W-1:0]    i_req_rid,
    // result side
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic [kidfl_pkg::ID_W-1:0]    o_res_id,
    output logic [kidfl_pkg::STATUS_W-1:0] o_res_status,
    // slot memory, word = {in_use, next link}
    output logic                          o_mem_re,
    output logic [$clog2(kidfl_pkg::CAPACITY)-1:0] o_mem_raddr,
    input  logic [$clog2(kidfl_pkg::CAPACITY+1):0] i_mem_rdata,
    output logic                          o_mem_we,
    output logic [$clog2(kidfl_pkg::CAPACITY)-1:0] o_mem_waddr,
    output logic [$clog2(kidfl_pkg::CAPACITY+1):0] o_mem_wdata
);
    import kidfl_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    t_state                r_state, n_state;
    logic [MODE_W-1:0]     r_mode;
    logic [ID_W-1:0]       r_rid;
    logic [CNT_W-1:0]      r_free_head, n_free_head;
    logic [CNT_W-1:0]      r_high_water, n_high_water;
    logic                  r_out_valid, n_out_valid;
    logic [ID_W-1:0]       r_out_id, n_out_id;
    t_status               r_out_status, n_out_status;

    logic                  accept;
    logic                  out_free;
    logic [ID_W-1:0]       in_rid_m1;
    logic [ID_W-1:0]       rid_m1;
    logic [CNT_W-1:0]      rd_next;
    logic                  rd_used;
    logic                  rel_ok;

    assign accept    = i_req_valid && o_req_ready;
    assign out_free  = !r_out_valid || i_res_ready;
    assign in_rid_m1 = i_req_rid - ID_W'(1);
    assign rid_m1    = r_rid - ID_W'(1);
    assign rd_next   = i_mem_rdata[CNT_W-1:0];
    assign rd_used   = i_mem_rdata[CNT_W];
    assign rel_ok    = (r_rid != '0) && (32'(r_rid) <= 32'(r_high_water)) && rd_used;

    // read issued with the accepted word: head slot for allocate, id slot otherwise
    assign o_mem_re    = accept;
    assign o_mem_raddr = (i_req_mode == MODE_ALLOC) ? r_free_head[SLOT_W-1:0]
                                                    : SLOT_W'(in_rid_m1);

    // request register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_req_mode;
            r_rid  <= i_req_rid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_free_head  <= '0;
            r_high_water <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_high_water <= n_high_water;
            r_out_valid  <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
    end

    // next state, list update and memory write-back
    always_comb begin
        n_state      = r_state;
        n_free_head  = r_free_head;
        n_high_water = r_high_water;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out_id     = r_out_id;
        n_out_status = r_out_status;
        o_req_ready  = 1'b0;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_free_head[SLOT_W-1:0];
        o_mem_wdata  = {1'b1, rd_next};

        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (out_free) begin
                    n_state      = ST_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_id     = '0;
                    n_out_status = STAT_OK;
                    unique case (r_mode)
                        MODE_ALLOC: begin
                            if (r_free_head == r_high_water) begin
                                if (r_high_water == CNT_W'(CAPACITY)) begin
                                    n_out_status = STAT_FULL;
                                end else begin
                                    // fresh slot at the high-water mark
                                    o_mem_we     = 1'b1;
                                    o_mem_waddr  = r_high_water[SLOT_W-1:0];
                                    n_high_water = r_high_water + CNT_W'(1);
                                    n_free_head  = r_high_water + CNT_W'(1);
                                    n_out_id     = ID_W'(r_high_water + CNT_W'(1));
                                end
                            end else begin
                                // pop the list head, keep its link
                                o_mem_we    = 1'b1;
                                n_free_head = rd_next;
                                n_out_id    = ID_W'(r_free_head + CNT_W'(1));
                            end
                        end
                        MODE_RELEASE: begin
                            if (rel_ok) begin
                                // push slot, link to old head, mark free
                                o_mem_we    = 1'b1;
                                o_mem_waddr = SLOT_W'(rid_m1);
                                o_mem_wdata = {1'b0, r_free_head};
                                n_free_head = CNT_W'(SLOT_W'(rid_m1));
                            end else begin
                                n_out_status = STAT_REJECT;
                            end
                        end
                        MODE_CLEAR: begin
                            n_free_head  = '0;
                            n_high_water = '0;
                            n_out_status = STAT_CLEARED;
                        end
                        default: begin
                            n_out_status = STAT_REJECT;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res_valid  = r_out_valid;
    assign o_res_id     = r_out_id;
    assign o_res_status = r_out_status;
endmodule

>>> rtl/core/key_id_free_list_allocator.sv
// Result: an accepted request moves the sequencer to ST_BUSY while its slot memory read is
//   registered; the result register loads on leaving ST_BUSY, once the output register is free.
// Requests: a new request is taken only after the current one has finished its slot memory read
//   and write-back and the sequencer is back in ST_IDLE.
// A waiting result sits in an output register; the next request is still accepted.
// Reset (synchronous, active low) empties the list and drops any pending result; no memory
//   clearing pass is needed, as slot contents at or above the high-water mark never matter.
module key_id_free_list_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [kidfl_pkg::DATA_W-1:0]      s_axis_tdata,  // [10:0] release_id
    input  logic [kidfl_pkg::MODE_W-1:0]      s_axis_tuser,  // [1:0] mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [kidfl_pkg::DATA_W-1:0]      m_axis_tdata,  // [10:0] granted_id
    output logic [kidfl_pkg::STATUS_W-1:0]    m_axis_tuser   // [1:0] status
);
    import kidfl_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int WORD_W = $clog2(CAPACITY + 1) + 1;

    logic                mem_re;
    logic [SLOT_W-1:0]   mem_raddr;
    logic [WORD_W-1:0]   mem_rdata;
    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic [ID_W-1:0]     res_id;

    // slot memory: in-use flag and next link per slot
    kidfl_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata)
    );

    // sequencer and list pointers
    kidfl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_req_mode   (s_axis_tuser),
        .i_req_rid    (s_axis_tdata[ID_W-1:0]),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res_id     (res_id),
        .o_res_status (m_axis_tuser),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata)
    );

    assign m_axis_tdata = DATA_W'(res_id);
endmodule

>>> rtl/core/kidfl_checker.sv
// Port-level checks for the allocator, bound to the top level.
module kidfl_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [kidfl_pkg::DATA_W-1:0]      s_axis_tdata,
    input logic [kidfl_pkg::MODE_W-1:0]      s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [kidfl_pkg::DATA_W-1:0]      m_axis_tdata,
    input logic [kidfl_pkg::STATUS_W-1:0]    m_axis_tuser
);
    import kidfl_pkg::*;

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // one request at a time: busy the cycle after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted back to back");

    // only a successful allocation carries a nonzero id, never above capacity
    a_id_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata == '0) ||
            (m_axis_tuser == STAT_OK && 32'(m_axis_tdata) <= 32'(CAPACITY)))
        else $error("bad granted id");

    // with the output empty at the accept, the result is valid once the request has left ST_BUSY
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("result late");

    // reset drops any pending result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
endmodule

bind key_id_free_list_allocator kidfl_checker u_kidfl_checker (.*);
